// ----- hdl/scg_pkg.sv -----
// Shared widths and types for the sphere contact geometry pipeline.
package scg_pkg;

  localparam int COORD_W     = 32;
  localparam int RAD_W       = 31;
  localparam int DIFF_W      = 33;
  localparam int SUMSQ_W     = 66;
  localparam int ROOT_W      = 35;
  localparam int NORM_BITS   = 30;
  localparam int QUO_W       = 31;
  localparam int NUM_W       = 64;
  localparam int LEVER_W     = 34;
  localparam int PROD_W      = 66;
  localparam int IN_TDATA_W  = 256;
  localparam int OUT_TDATA_W = 224;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] ctr_a;
    logic [RAD_W-1:0]        rad_a;
    logic [RAD_W-1:0]        rad_b;
    logic [2:0]              neg;
  } side_t;

  typedef struct packed {
    logic en;
    logic valid;
  } pipe_t;

endpackage

// ----- hdl/sphere_contact_geometry.sv -----
// Top level of the sphere-sphere contact geometry pipeline.
// Usage:
//   Slave stream carries one sphere pair per beat; master stream returns one
//   contact record per beat, in order. No configuration, no kept state.
//   An accepted beat passes to a valid result through 4 front stages
//   (difference, magnitude, square, sum), 35 square-root stages (one root bit
//   each), 32 divider stages (setup plus one quotient bit each) and 4 back
//   stages (penetration, lever product, rounding, contact sum and clamp).
//   Throughput is one pair per cycle while the receiver does not stall; the
//   bit-per-stage root and divider chains set the depth.
//   Reset clears all valid bits; the pipeline is empty afterwards.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and s_axis_tready drops; nothing is lost or repeated. While the output
//   slot is empty or being taken, the pipeline advances and takes a new beat.
//   Coincident centers give a zero normal and raise tuser.
module sphere_contact_geometry (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // ctr_a x,y,z, ctr_b x,y,z, radius_a, radius_b, 2 zero pad bits
  input  logic [scg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // normal x,y,z, penetration, contact x,y,z
  output logic [scg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // coincident
  output logic                               m_axis_tuser
);

  localparam int CW = scg_pkg::COORD_W;

  logic           en;
  scg_pkg::pipe_t fr_ctl, sq_ctl, dv_ctl, ct_ctl;

  logic [2:0][CW-1:0] ctr_a, ctr_b;
  logic                                fr_valid, sq_valid, dv_valid;
  logic [scg_pkg::SUMSQ_W-1:0]         fr_sum;
  logic [2:0][scg_pkg::DIFF_W-1:0]     fr_mag, sq_mag;
  scg_pkg::side_t                      fr_side, sq_side, dv_side;
  logic [scg_pkg::ROOT_W-1:0]          sq_root, dv_dist;
  logic [2:0][scg_pkg::QUO_W-1:0]      dv_quo;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign ctr_a[i] = s_axis_tdata[i*CW +: CW];
    assign ctr_b[i] = s_axis_tdata[(i+3)*CW +: CW];
  end

  assign fr_ctl = '{en: en, valid: s_axis_tvalid};
  assign sq_ctl = '{en: en, valid: fr_valid};
  assign dv_ctl = '{en: en, valid: sq_valid};
  assign ct_ctl = '{en: en, valid: dv_valid};

  scg_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (fr_ctl),
    .ctr_a_i (ctr_a),
    .ctr_b_i (ctr_b),
    .rad_a_i (s_axis_tdata[6*CW +: scg_pkg::RAD_W]),
    .rad_b_i (s_axis_tdata[6*CW+scg_pkg::RAD_W +: scg_pkg::RAD_W]),
    .valid_o (fr_valid),
    .sumsq_o (fr_sum),
    .mag_o   (fr_mag),
    .side_o  (fr_side)
  );

  scg_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (sq_ctl),
    .sumsq_i (fr_sum),
    .mag_i   (fr_mag),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .mag_o   (sq_mag),
    .side_o  (sq_side)
  );

  scg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (dv_ctl),
    .dist_i  (sq_root),
    .mag_i   (sq_mag),
    .side_i  (sq_side),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .dist_o  (dv_dist),
    .side_o  (dv_side)
  );

  scg_contact u_contact (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ct_ctl),
    .quo_i   (dv_quo),
    .dist_i  (dv_dist),
    .side_i  (dv_side),
    .valid_o (m_axis_tvalid),
    .tdata_o (m_axis_tdata),
    .coinc_o (m_axis_tuser)
  );

`ifndef SYNTH
  a_coinc_zero_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[3*CW-1:0] == '0)
    else $error("coincident beat with nonzero normal");

  a_normal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      $signed(m_axis_tdata[CW-1:0]) <= $signed(32'sh4000_0000) &&
      $signed(m_axis_tdata[CW-1:0]) >= $signed(-32'sh4000_0000))
    else $error("normal x out of unit range");

  a_coinc_pen_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[4*CW-1])
    else $error("coincident beat with negative penetration");
`endif

endmodule

// ----- hdl/scg_front.sv -----
// Front stages: center difference, magnitude, squares and sum of squares.
module scg_front (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  scg_pkg::pipe_t                              ctl_i,
  input  logic [2:0][scg_pkg::COORD_W-1:0]            ctr_a_i,
  input  logic [2:0][scg_pkg::COORD_W-1:0]            ctr_b_i,
  input  logic [scg_pkg::RAD_W-1:0]                   rad_a_i,
  input  logic [scg_pkg::RAD_W-1:0]                   rad_b_i,
  output logic                                        valid_o,
  output logic [scg_pkg::SUMSQ_W-1:0]                 sumsq_o,
  output logic [2:0][scg_pkg::DIFF_W-1:0]             mag_o,
  output scg_pkg::side_t                              side_o
);

  logic [3:0] v_q;
  logic [2:0][scg_pkg::DIFF_W-1:0]  d1_q, mag2_q, mag3_q, mag4_q;
  logic [2:0][scg_pkg::SUMSQ_W-1:0] sq3_q;
  logic [scg_pkg::SUMSQ_W-1:0]      sum4_q;
  scg_pkg::side_t side1_q, side2_q, side3_q, side4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (ctl_i.en) begin
      v_q <= {v_q[2:0], ctl_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      for (int i = 0; i < 3; i++) begin
        d1_q[i] <= scg_pkg::DIFF_W'($signed({ctr_b_i[i][scg_pkg::COORD_W-1], ctr_b_i[i]})
                 - $signed({ctr_a_i[i][scg_pkg::COORD_W-1], ctr_a_i[i]}));
        mag2_q[i] <= d1_q[i][scg_pkg::DIFF_W-1] ? (~d1_q[i] + 1'b1) : d1_q[i];
        sq3_q[i]  <= scg_pkg::SUMSQ_W'(mag2_q[i] * mag2_q[i]);
      end
      side1_q       <= '{ctr_a: ctr_a_i, rad_a: rad_a_i, rad_b: rad_b_i, neg: 3'b000};
      side2_q       <= '{ctr_a: side1_q.ctr_a, rad_a: side1_q.rad_a, rad_b: side1_q.rad_b,
                         neg: {d1_q[2][scg_pkg::DIFF_W-1], d1_q[1][scg_pkg::DIFF_W-1],
                               d1_q[0][scg_pkg::DIFF_W-1]}};
      side3_q       <= side2_q;
      side4_q       <= side3_q;
      mag3_q        <= mag2_q;
      mag4_q        <= mag3_q;
      sum4_q        <= sq3_q[0] + sq3_q[1] + sq3_q[2];
    end
  end

  assign valid_o = v_q[3];
  assign sumsq_o = sum4_q;
  assign mag_o   = mag4_q;
  assign side_o  = side4_q;

endmodule

// ----- hdl/scg_sqrt.sv -----
// Bit-per-stage restoring integer square root of the sum of squares.
module scg_sqrt (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  scg_pkg::pipe_t                      ctl_i,
  input  logic [scg_pkg::SUMSQ_W-1:0]         sumsq_i,
  input  logic [2:0][scg_pkg::DIFF_W-1:0]     mag_i,
  input  scg_pkg::side_t                      side_i,
  output logic                                valid_o,
  output logic [scg_pkg::ROOT_W-1:0]          root_o,
  output logic [2:0][scg_pkg::DIFF_W-1:0]     mag_o,
  output scg_pkg::side_t                      side_o
);

  localparam int N  = scg_pkg::ROOT_W;
  localparam int TW = 2 * scg_pkg::ROOT_W + 2;

  logic [N-1:0]                    v_q;
  logic [scg_pkg::ROOT_W-1:0]      r_q   [N];
  logic [scg_pkg::SUMSQ_W-1:0]     rem_q [N];
  logic [2:0][scg_pkg::DIFF_W-1:0] mag_q [N];
  scg_pkg::side_t                  side_q[N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (ctl_i.en) begin
      v_q <= {v_q[N-2:0], ctl_i.valid};
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam int B = N - 1 - s;
    logic [scg_pkg::ROOT_W-1:0]      r_in;
    logic [scg_pkg::SUMSQ_W-1:0]     rem_in;
    logic [2:0][scg_pkg::DIFF_W-1:0] mag_in;
    scg_pkg::side_t                  side_in;
    logic [TW-1:0]                   trial;
    logic                            take;

    if (s == 0) begin : g_first
      assign r_in    = '0;
      assign rem_in  = sumsq_i;
      assign mag_in  = mag_i;
      assign side_in = side_i;
    end else begin : g_next
      assign r_in    = r_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign mag_in  = mag_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign trial = (TW'(r_in) << (B + 1)) + (TW'(1) << (2 * B));
    assign take  = TW'(rem_in) >= trial;

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        r_q[s]    <= take ? (r_in | (scg_pkg::ROOT_W'(1) << B)) : r_in;
        rem_q[s]  <= take ? (rem_in - trial[scg_pkg::SUMSQ_W-1:0]) : rem_in;
        mag_q[s]  <= mag_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign root_o  = r_q[N-1];
  assign mag_o   = mag_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

// ----- hdl/scg_div.sv -----
// Three-lane bit-per-stage divider: rounded normal magnitudes in Q1.30.
module scg_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  scg_pkg::pipe_t                      ctl_i,
  input  logic [scg_pkg::ROOT_W-1:0]          dist_i,
  input  logic [2:0][scg_pkg::DIFF_W-1:0]     mag_i,
  input  scg_pkg::side_t                      side_i,
  output logic                                valid_o,
  output logic [2:0][scg_pkg::QUO_W-1:0]      quo_o,
  output logic [scg_pkg::ROOT_W-1:0]          dist_o,
  output scg_pkg::side_t                      side_o
);

  localparam int N  = scg_pkg::QUO_W;
  localparam int CW = scg_pkg::NUM_W + 2;

  logic [N:0]                      v_q;
  logic [2:0][scg_pkg::NUM_W-1:0]  num_q [N+1];
  logic [2:0][scg_pkg::QUO_W-1:0]  quo_q [N+1];
  logic [scg_pkg::ROOT_W-1:0]      den_q [N+1];
  scg_pkg::side_t                  side_q[N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (ctl_i.en) begin
      v_q <= {v_q[N-1:0], ctl_i.valid};
    end
  end

  // rounding: numerator gets half the divisor added up front
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      for (int i = 0; i < 3; i++) begin
        num_q[0][i] <= (scg_pkg::NUM_W'(mag_i[i]) << scg_pkg::NORM_BITS)
                     + scg_pkg::NUM_W'(dist_i >> 1);
      end
      quo_q[0]  <= '0;
      den_q[0]  <= dist_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar s = 1; s <= N; s++) begin : g_stage
    localparam int K = N - s;
    logic [CW-1:0] dsh;
    logic [2:0]    take;

    assign dsh = CW'(den_q[s-1]) << K;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        take[i] = CW'(num_q[s-1][i]) >= dsh;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        for (int i = 0; i < 3; i++) begin
          num_q[s][i] <= take[i] ? (num_q[s-1][i] - dsh[scg_pkg::NUM_W-1:0])
                                 : num_q[s-1][i];
          quo_q[s][i] <= quo_q[s-1][i] | (scg_pkg::QUO_W'(take[i]) << K);
        end
        den_q[s]  <= den_q[s-1];
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign valid_o = v_q[N];
  assign quo_o   = quo_q[N];
  assign dist_o  = den_q[N];
  assign side_o  = side_q[N];

endmodule

// ----- hdl/scg_contact.sv -----
// Back stages: signed normal, penetration, lever product and contact point.
module scg_contact (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  scg_pkg::pipe_t                        ctl_i,
  input  logic [2:0][scg_pkg::QUO_W-1:0]        quo_i,
  input  logic [scg_pkg::ROOT_W-1:0]            dist_i,
  input  scg_pkg::side_t                        side_i,
  output logic                                  valid_o,
  output logic [scg_pkg::OUT_TDATA_W-1:0]       tdata_o,
  output logic                                  coinc_o
);

  localparam int CW = scg_pkg::COORD_W;

  logic [3:0] v_q;

  logic signed [2:0][CW-1:0]              n1_q, n2_q, n3_q, n4_q;
  logic signed [scg_pkg::LEVER_W-1:0]     lev1_q;
  logic [CW-1:0]                          pen1_q, pen2_q, pen3_q, pen4_q;
  logic                                   co1_q, co2_q, co3_q, co4_q;
  logic [2:0][CW-1:0]                     a1_q, a2_q, a3_q;
  logic signed [2:0][scg_pkg::PROD_W-1:0] p2_q;
  logic [2:0][scg_pkg::PROD_W-1:0]        pm3_q;
  logic [2:0]                             pn3_q;
  logic [2:0][CW-1:0]                     c4_q;

  logic signed [CW+4:0] pen_w;
  logic [CW-1:0]        pen_d;
  logic signed [scg_pkg::LEVER_W-1:0] lev_d;
  logic signed [2:0][CW-1:0]          n_d;
  logic [2:0][CW-1:0]                 c_d;

  always_comb begin
    pen_w = $signed({6'b0, side_i.rad_a}) + $signed({6'b0, side_i.rad_b})
          - $signed({2'b0, dist_i});
    if (pen_w > $signed(37'sh0_7FFF_FFFF)) begin
      pen_d = 32'h7FFF_FFFF;
    end else if (pen_w < $signed(-37'sh0_8000_0000)) begin
      pen_d = 32'h8000_0000;
    end else begin
      pen_d = pen_w[CW-1:0];
    end
    lev_d = $signed({2'b0, side_i.rad_a, 1'b0}) - $signed({{2{pen_d[CW-1]}}, pen_d});
    for (int i = 0; i < 3; i++) begin
      if (dist_i == '0) begin
        n_d[i] = '0;
      end else if (side_i.neg[i]) begin
        n_d[i] = -$signed({1'b0, quo_i[i]});
      end else begin
        n_d[i] = $signed({1'b0, quo_i[i]});
      end
    end
  end

  always_comb begin
    logic [34:0]          mq;
    logic signed [35:0]   off;
    logic signed [36:0]   sum;
    for (int i = 0; i < 3; i++) begin
      mq  = pm3_q[i][scg_pkg::PROD_W-1:31];
      off = pn3_q[i] ? -$signed({1'b0, mq}) : $signed({1'b0, mq});
      sum = $signed({{5{a3_q[i][CW-1]}}, a3_q[i]}) + $signed({off[35], off});
      if (sum > $signed(37'sh0_7FFF_FFFF)) begin
        c_d[i] = 32'h7FFF_FFFF;
      end else if (sum < $signed(-37'sh0_8000_0000)) begin
        c_d[i] = 32'h8000_0000;
      end else begin
        c_d[i] = sum[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (ctl_i.en) begin
      v_q <= {v_q[2:0], ctl_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      n1_q   <= n_d;
      lev1_q <= lev_d;
      pen1_q <= pen_d;
      co1_q  <= dist_i == '0;
      a1_q   <= side_i.ctr_a;
      for (int i = 0; i < 3; i++) begin
        p2_q[i]  <= lev1_q * $signed(n1_q[i]);
        pn3_q[i] <= p2_q[i][scg_pkg::PROD_W-1];
        pm3_q[i] <= (p2_q[i][scg_pkg::PROD_W-1] ? (~p2_q[i] + 1'b1) : p2_q[i])
                  + (scg_pkg::PROD_W'(1) << scg_pkg::NORM_BITS);
      end
      n2_q   <= n1_q;
      n3_q   <= n2_q;
      n4_q   <= n3_q;
      pen2_q <= pen1_q;
      pen3_q <= pen2_q;
      pen4_q <= pen3_q;
      co2_q  <= co1_q;
      co3_q  <= co2_q;
      co4_q  <= co3_q;
      a2_q   <= a1_q;
      a3_q   <= a2_q;
      c4_q   <= c_d;
    end
  end

  assign valid_o = v_q[3];
  assign coinc_o = co4_q;
  assign tdata_o = {c4_q[2], c4_q[1], c4_q[0], pen4_q, n4_q[2], n4_q[1], n4_q[0]};

endmodule

// ----- dv/tb_sphere_contact_geometry.sv -----
// Testbench for the sphere contact geometry pipeline: directed and random pairs, scoreboarded.
module tb_sphere_contact_geometry;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] ax, ay, az, bx, by, bz;
    logic [30:0]        ra, rb;
  } pair_t;

  typedef struct {
    logic [31:0] nx, ny, nz, pen, cx, cy, cz;
    logic        coin;
  } contact_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [scg_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [scg_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  contact_t expected_contacts[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  sphere_contact_geometry dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] clamp32(logic signed [95:0] v);
    if (v > 96'sd2147483647) return 32'h7fffffff;
    if (v < -96'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic contact_t predict_contact(pair_t p);
    contact_t r;
    logic signed [95:0] a[3], d[3], n[3], pen, lever2, prod, off;
    logic [95:0] sumsq, root, trial, mag, q;
    a[0] = p.ax; a[1] = p.ay; a[2] = p.az;
    d[0] = 96'(p.bx) - a[0];
    d[1] = 96'(p.by) - a[1];
    d[2] = 96'(p.bz) - a[2];
    sumsq = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
    root = 0;
    for (int b = 34; b >= 0; b--) begin
      trial = root | (96'd1 << b);
      if (trial * trial <= sumsq) root = trial;
    end
    for (int i = 0; i < 3; i++) begin
      if (root == 0) n[i] = 0;
      else begin
        mag = d[i] < 0 ? -d[i] : d[i];
        q = ((mag << 30) + root / 2) / root;
        n[i] = d[i] < 0 ? -$signed(q) : $signed(q);
      end
    end
    pen = clamp32(96'(p.ra) + 96'(p.rb) - $signed(root));
    lever2 = 2 * 96'(p.ra) - pen;
    r.nx = n[0][31:0]; r.ny = n[1][31:0]; r.nz = n[2][31:0];
    r.pen = pen[31:0];
    for (int i = 0; i < 3; i++) begin
      prod = lever2 * n[i];
      mag = prod < 0 ? -prod : prod;
      mag = (mag + (96'd1 << 30)) >> 31;
      off = prod < 0 ? -$signed(mag) : $signed(mag);
      case (i)
        0: r.cx = clamp32(a[i] + off);
        1: r.cy = clamp32(a[i] + off);
        default: r.cz = clamp32(a[i] + off);
      endcase
    end
    r.coin = (root == 0);
    return r;
  endfunction

  task automatic send_pair(pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    expected_contacts.push_back(predict_contact(p));
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b0, p.rb, p.ra, p.bz, p.by, p.bx, p.az, p.ay, p.ax};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  always @(posedge clk_i) begin
    contact_t e, g;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        {g.cz, g.cy, g.cx, g.pen, g.nz, g.ny, g.nx} = m_axis_tdata;
        g.coin = m_axis_tuser;
        if (expected_contacts.size() == 0) begin
          $error("unexpected result beat");
          errors++;
        end else begin
          e = expected_contacts.pop_front();
          if (g.nx !== e.nx) begin $error("normal_x exp %h got %h", e.nx, g.nx); errors++; end
          if (g.ny !== e.ny) begin $error("normal_y exp %h got %h", e.ny, g.ny); errors++; end
          if (g.nz !== e.nz) begin $error("normal_z exp %h got %h", e.nz, g.nz); errors++; end
          if (g.pen !== e.pen) begin
            $error("penetration exp %h got %h", e.pen, g.pen); errors++;
          end
          if (g.cx !== e.cx) begin $error("contact_x exp %h got %h", e.cx, g.cx); errors++; end
          if (g.cy !== e.cy) begin $error("contact_y exp %h got %h", e.cy, g.cy); errors++; end
          if (g.cz !== e.cz) begin $error("contact_z exp %h got %h", e.cz, g.cz); errors++; end
          if (g.coin !== e.coin) begin
            $error("coincident exp %b got %b", e.coin, g.coin); errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(2000000)) - 1000000;
      default: return $signed($urandom_range(200)) - 100;
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int mode = $urandom_range(2);
    p.ax = rand_coord(mode); p.ay = rand_coord(mode); p.az = rand_coord(mode);
    p.bx = rand_coord(mode); p.by = rand_coord(mode); p.bz = rand_coord(mode);
    if ($urandom_range(9) == 0) begin
      p.bx = p.ax; p.by = p.ay; p.bz = p.az;
    end
    p.ra = $urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(3000000));
    p.rb = $urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(3000000));
    return p;
  endfunction

  function automatic pair_t mk(logic [31:0] ax, ay, az, bx, by, bz, logic [30:0] ra, rb);
    pair_t p;
    p.ax = ax; p.ay = ay; p.az = az; p.bx = bx; p.by = by; p.bz = bz;
    p.ra = ra; p.rb = rb;
    return p;
  endfunction

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_contacts.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(mk(5, 5, 5, 5, 5, 5, 31'h7fffffff, 31'h7fffffff));
    send_pair(mk(0, 0, 0, 32'h10000, 0, 0, 31'h8000, 31'h8000));
    send_pair(mk(0, 0, 0, 0, 32'hffff0000, 0, 31'h10000, 31'h10000));
    send_pair(mk(0, 0, 0, 0, 0, 32'h30000, 31'h10000, 31'h10000));
    send_pair(mk(32'h80000000, 32'h80000000, 32'h80000000,
                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0));
    send_pair(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff, 31'h7fffffff));
    send_pair(mk(32'h7fffffff, 0, 0, 32'h7ffffff0, 0, 0, 31'h7fffffff, 0));
    send_pair(mk(32'h80000000, 0, 0, 32'h80000010, 0, 0, 31'h7fffffff, 31'h7fffffff));
    send_pair(mk(0, 0, 0, 3, 4, 0, 1, 1));
    send_pair(mk(0, 0, 0, 1, 1, 1, 0, 31'h7fffffff));
    send_pair(mk(32'h12345678, 32'hedcba987, 32'h55555555,
                 32'haaaaaaaa, 32'h0f0f0f0f, 32'hf0f0f0f0, 31'h2aaaaaaa, 31'h55555555));
    send_pair(mk(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0, 31'h7fffffff, 1));
  endtask

  task automatic test_random(int count, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (count) send_pair(rand_pair());
  endtask

  task automatic test_pause_until_drained();
    drain();
    repeat (5) send_pair(rand_pair());
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(100, 0, 0);
    test_random(100, 46, 0);
    test_pause_until_drained();
    test_random(100, 0, 46);
    test_random(100, 19, 19);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
